// ===== src/nsr_pkg.sv =====
`default_nettype none

package nsr_pkg;

   localparam int FRAC_BITS = 16;
   localparam int IN_W = 32;
   localparam int NUM_W = IN_W + FRAC_BITS;
   localparam int EST_W = 32;
   localparam int ROOT_W = 24;
   localparam int ROUND_W = 6;
   localparam int CNT_W = $clog2(NUM_W);

   localparam logic [ROUND_W-1:0] LIMIT_RESET = ROUND_W'(32);
   localparam logic [ROUND_W-1:0] LIMIT_MIN = ROUND_W'(1);
   localparam logic [ROOT_W-1:0] ROOT_MAX = {ROOT_W{1'b1}};
   localparam logic [EST_W-1:0] EST_UNIT = EST_W'(1);
   localparam logic [EST_W-1:0] EST_ONE = EST_UNIT << FRAC_BITS;

   typedef struct packed {
      logic load;
      logic div_start;
      logic div_step;
      logic update;
      logic out_load;
   } nsr_cmd_type;

   typedef struct packed {
      logic trivial;
      logic div_last;
      logic stop;
   } nsr_status_type;

endpackage

`default_nettype wire

// ===== src/nsr_req_if.sv =====
`default_nettype none

interface nsr_req_if import nsr_pkg::*; ();
   logic            valid;
   logic            ready;
   logic [IN_W-1:0] radicand;

   modport source (output valid, output radicand, input ready);
   modport sink (input valid, input radicand, output ready);
endinterface

`default_nettype wire

// ===== src/nsr_rsp_if.sv =====
`default_nettype none

interface nsr_rsp_if import nsr_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [ROOT_W-1:0]  root;
   logic               negative_input;
   logic               hit_limit;
   logic [ROUND_W-1:0] rounds_used;

   modport source (output valid, output root, output negative_input, output hit_limit,
                   output rounds_used, input ready);
   modport sink (input valid, input root, input negative_input, input hit_limit,
                 input rounds_used, output ready);
endinterface

`default_nettype wire

// ===== src/nsr_csr_if.sv =====
`default_nettype none

interface nsr_csr_if import nsr_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [ROUND_W-1:0] iteration_limit;

   modport source (output valid, output iteration_limit, input ready);
   modport sink (input valid, input iteration_limit, output ready);
endinterface

`default_nettype wire

// ===== src/nsr_datapath.sv =====
`default_nettype none

module nsr_datapath import nsr_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire nsr_cmd_type        cmd,
   output nsr_status_type          status,
   input  wire logic [IN_W-1:0]    radicand,
   input  wire logic               cfg_write,
   input  wire logic [ROUND_W-1:0] cfg_limit,
   output logic [ROOT_W-1:0]       root,
   output logic                    negative_input,
   output logic                    hit_limit,
   output logic [ROUND_W-1:0]      rounds_used
);

   logic [ROUND_W-1:0] limit_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic [NUM_W-1:0]   num_ff;
   logic               neg_ff;
   logic [EST_W-1:0]   est_ff;
   logic [ROUND_W-1:0] rounds_ff;
   logic               hit_ff;
   logic [NUM_W-1:0]   quo_ff;
   logic [EST_W-1:0]   rem_ff;
   logic [ROOT_W-1:0]  root_ff;
   logic               neg_out_ff;
   logic               hit_out_ff;
   logic [ROUND_W-1:0] rounds_out_ff;

   logic [EST_W-1:0]   divisor;
   logic [EST_W:0]     partial;
   logic [EST_W:0]     trial;
   logic               trial_ok;
   logic [NUM_W-1:0]   quo_in;
   logic [EST_W-1:0]   rem_in;
   logic [NUM_W:0]     sum;
   logic [NUM_W-1:0]   next_est;
   logic [NUM_W-1:0]   est_wide;
   logic               converged;
   logic               rising;
   logic               limited;
   logic [ROUND_W-1:0] rounds_in;
   logic [ROUND_W-1:0] limit_eff;
   logic [ROOT_W-1:0]  root_sat;

   // restoring divide step, one quotient bit a cycle
   always_comb begin
      divisor = (est_ff == '0) ? EST_UNIT : est_ff;
      partial = {rem_ff, quo_ff[NUM_W-1]};
      trial = partial - {1'b0, divisor};
      trial_ok = !trial[EST_W];
      quo_in = {quo_ff[NUM_W-2:0], trial_ok};
      rem_in = trial_ok ? trial[EST_W-1:0] : partial[EST_W-1:0];
   end

   // round decision
   always_comb begin
      est_wide = NUM_W'(est_ff);
      sum = {1'b0, est_wide} + {1'b0, quo_ff};
      next_est = sum[NUM_W:1];
      converged = (next_est == est_wide);
      rising = (rounds_ff != '0) && (next_est > est_wide);
      rounds_in = rounds_ff + ROUND_W'(1);
      limit_eff = (limit_ff == '0) ? LIMIT_MIN : limit_ff;
      limited = (rounds_in >= limit_eff);
      root_sat = (est_ff > EST_W'(ROOT_MAX)) ? ROOT_MAX : est_ff[ROOT_W-1:0];
   end

   always_comb begin
      status.trivial = radicand[IN_W-1] || (radicand == '0);
      status.div_last = (cnt_ff == CNT_W'(NUM_W - 1));
      status.stop = converged || rising || limited;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
         cnt_ff <= '0;
      end else begin
         if (cfg_write) begin
            limit_ff <= cfg_limit;
         end
         if (cmd.div_start) begin
            cnt_ff <= '0;
         end else if (cmd.div_step) begin
            cnt_ff <= cnt_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         num_ff <= {radicand, {FRAC_BITS{1'b0}}};
         neg_ff <= radicand[IN_W-1];
         est_ff <= status.trivial ? '0 : EST_ONE;
         rounds_ff <= '0;
         hit_ff <= 1'b0;
      end
      if (cmd.div_start) begin
         quo_ff <= num_ff;
         rem_ff <= '0;
      end else if (cmd.div_step) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
      if (cmd.update) begin
         rounds_ff <= rounds_in;
         if (!converged && !rising) begin
            est_ff <= next_est[EST_W-1:0];
         end
         hit_ff <= limited && !converged && !rising;
      end
      if (cmd.out_load) begin
         root_ff <= root_sat;
         neg_out_ff <= neg_ff;
         hit_out_ff <= hit_ff;
         rounds_out_ff <= rounds_ff;
      end
   end

   assign root = root_ff;
   assign negative_input = neg_out_ff;
   assign hit_limit = hit_out_ff;
   assign rounds_used = rounds_out_ff;

endmodule

`default_nettype wire

// ===== src/nsr_ctrl.sv =====
`default_nettype none

module nsr_ctrl import nsr_pkg::*; (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  wire logic           rsp_ready,
   output nsr_cmd_type         cmd,
   input  wire nsr_status_type status
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_START  = 3'd1;
   localparam logic [2:0] ST_DIVIDE = 3'd2;
   localparam logic [2:0] ST_DECIDE = 3'd3;
   localparam logic [2:0] ST_FINISH = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       out_valid_ff;
   logic       out_valid_in;

   always_comb begin
      cmd = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = status.trivial ? ST_FINISH : ST_START;
            end
         end
         ST_START: begin
            cmd.div_start = 1'b1;
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            cmd.update = 1'b1;
            state_in = status.stop ? ST_FINISH : ST_START;
         end
         ST_FINISH: begin
            // wait for the output register to be free
            if (!out_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = out_valid_ff;

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH) && out_valid_ff && !rsp_ready |=> (state_ff == ST_FINISH))
      else $error("finished result dropped while output register busy");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DECIDE) && status.stop |=> (state_ff == ST_FINISH))
      else $error("stop decision did not end the rounds");

   assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> ($past(state_ff) == ST_FINISH))
      else $error("result presented without finishing an item");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE) && !status.div_last |=> (state_ff == ST_DIVIDE))
      else $error("division left before its last step");

endmodule

`default_nettype wire

// ===== src/newton_square_root.sv =====
`default_nettype none

// Newton square root of a signed Q16.16 number, result in unsigned Q8.16.
// req_bus: valid/ready channel carrying radicand; a transfer starts one item.
// rsp_bus: valid/ready channel carrying root, negative_input, hit_limit and
//    rounds_used; one transfer per item, in order.
// csr_bus: valid/ready write of iteration_limit, always ready; write only
//    while no item is in flight.
// Sequence: a negative or zero radicand skips the rounds and goes from the
//    req transfer straight to the finish state. Otherwise each round is one
//    serial restoring divide of 48 bits (one quotient bit a cycle) plus a
//    start and an update state. Rounds are at most iteration_limit (1 if 0).
// Throughput: one item at a time; req ready is high only while idle. A
//    finished result sits in an output register, so the next item is taken
//    while the previous result waits.
// Receiver stall: the result holds on rsp_bus; if the next item finishes
//    first, it waits until the output register is free.
// Reset: synchronous, active high; clears the flow control and sets
//    iteration_limit to 32.
module newton_square_root import nsr_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   nsr_req_if.sink    req_bus,
   nsr_rsp_if.source  rsp_bus,
   nsr_csr_if.sink    csr_bus
);

   nsr_cmd_type    cmd;
   nsr_status_type status;

   nsr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .cmd       (cmd),
      .status    (status)
   );

   nsr_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .radicand       (req_bus.radicand),
      .cfg_write      (csr_bus.valid),
      .cfg_limit      (csr_bus.iteration_limit),
      .root           (rsp_bus.root),
      .negative_input (rsp_bus.negative_input),
      .hit_limit      (rsp_bus.hit_limit),
      .rounds_used    (rsp_bus.rounds_used)
   );

   assign csr_bus.ready = 1'b1;

endmodule

`default_nettype wire

// ===== sim/nsr_root_checker.sv =====
`default_nettype none

module nsr_root_checker import nsr_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   nsr_req_if        req,
   nsr_rsp_if        rsp,
   nsr_csr_if        csr,
   output int        mismatches,
   output int        outstanding
);

   typedef struct packed {
      logic [ROOT_W-1:0]  root;
      logic               negative_input;
      logic               hit_limit;
      logic [ROUND_W-1:0] rounds_used;
   } root_result_t;

   root_result_t       expected_roots[$];
   logic [ROUND_W-1:0] limit_copy;

   function automatic root_result_t newton_root(logic [IN_W-1:0] radicand,
                                                logic [ROUND_W-1:0] limit_reg);
      root_result_t res;
      logic [63:0]  num;
      logic [63:0]  est;
      logic [63:0]  quot;
      logic [63:0]  nxt;
      int unsigned  cap;
      int unsigned  rounds;
      logic         capped;
      logic         done;
      res = '0;
      cap = (limit_reg == '0) ? 1 : int'(limit_reg);
      if (radicand[IN_W-1]) begin
         res.negative_input = 1'b1;
         return res;
      end
      if (radicand == '0) begin
         return res;
      end
      num = 64'(radicand) << FRAC_BITS;
      est = 64'(EST_ONE);
      rounds = 0;
      capped = 1'b0;
      done = 1'b0;
      while (!done) begin
         quot = num / ((est == 64'd0) ? 64'd1 : est);
         nxt = (est + quot) >> 1;
         rounds++;
         if (nxt == est) begin
            done = 1'b1;
         end else if (rounds > 1 && nxt > est) begin
            // stopped falling, keep the smaller estimate
            done = 1'b1;
         end else begin
            est = nxt;
            if (rounds >= cap) begin
               capped = 1'b1;
               done = 1'b1;
            end
         end
      end
      res.root = (est > 64'(ROOT_MAX)) ? ROOT_MAX : est[ROOT_W-1:0];
      res.hit_limit = capped;
      res.rounds_used = rounds[ROUND_W-1:0];
      return res;
   endfunction

   function automatic int field_differs(string field, logic [31:0] want_v,
                                        logic [31:0] got_v);
      if (want_v !== got_v) begin
         $error("%s: expected 0x%0h, got 0x%0h", field, want_v, got_v);
         return 1;
      end
      return 0;
   endfunction

   always @(posedge clock) begin : watch
      root_result_t want;
      int           bad;
      int           delta;
      if (reset) begin
         limit_copy <= LIMIT_RESET;
         expected_roots.delete();
         outstanding <= 0;
         mismatches <= 0;
      end else begin
         bad = 0;
         delta = 0;
         if (csr.valid && csr.ready) begin
            limit_copy <= csr.iteration_limit;
         end
         if (req.valid && req.ready) begin
            expected_roots.push_back(newton_root(req.radicand, limit_copy));
            delta++;
         end
         if (rsp.valid && rsp.ready) begin
            if (expected_roots.size() == 0) begin
               $error("result transfer with no result expected");
               bad++;
            end else begin
               want = expected_roots.pop_front();
               delta--;
               bad += field_differs("root", 32'(want.root), 32'(rsp.root));
               bad += field_differs("negative_input", 32'(want.negative_input),
                                    32'(rsp.negative_input));
               bad += field_differs("hit_limit", 32'(want.hit_limit),
                                    32'(rsp.hit_limit));
               bad += field_differs("rounds_used", 32'(want.rounds_used),
                                    32'(rsp.rounds_used));
            end
         end
         outstanding <= outstanding + delta;
         mismatches <= mismatches + bad;
      end
   end

endmodule

`default_nettype wire

// ===== sim/newton_square_root_tb.sv =====
`default_nettype none

module newton_square_root_tb;
   import nsr_pkg::*;

   localparam int HOLD_CYCLES = 4000;
   localparam int HOLD_AT = 30;
   localparam int NUM_PHASES = 5;

   logic clock;
   logic reset;
   int   mismatches;
   int   outstanding;
   int   sent;
   int   taken;
   logic held;

   nsr_req_if req_bus();
   nsr_rsp_if rsp_bus();
   nsr_csr_if csr_bus();

   newton_square_root DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   nsr_root_checker root_check (
      .clock       (clock),
      .reset       (reset),
      .req         (req_bus),
      .rsp         (rsp_bus),
      .csr         (csr_bus),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #72_000_000;
      $display("newton_square_root_tb NOT OK");
      $finish;
   end

   task automatic wait_drained();
      // let the count see the last transfer first
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic push_radicand(input logic [IN_W-1:0] value);
      logic calm;
      calm = (sent >= 200 && sent < 320);
      if (!calm && $urandom_range(99) < 10) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.radicand <= value;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      sent++;
   endtask

   task automatic write_limit(input logic [ROUND_W-1:0] value);
      req_bus.valid <= 1'b0;
      wait_drained();
      repeat (10) @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.iteration_limit <= value;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   function automatic logic [IN_W-1:0] random_radicand();
      logic [IN_W-1:0] v;
      int unsigned     k;
      case ($urandom_range(9))
         0, 1, 2: v = $urandom;
         3, 4:    v = {1'b0, 31'($urandom)} >> $urandom_range(31);
         5:       v = {1'b1, 31'($urandom)};
         6:       v = $urandom_range(0, 255);
         7: begin
            k = $urandom_range(1, 181);
            v = IN_W'(k * k) << FRAC_BITS;
         end
         8:       v = 32'h7FFF_FFFF - $urandom_range(0, 1023);
         default: v = 32'h0000_FFE0 + $urandom_range(0, 64);
      endcase
      return v;
   endfunction

   // result side: random stalls, one long hold-off, and a quiet stretch
   initial begin
      rsp_bus.ready = 1'b0;
      taken = 0;
      held = 1'b0;
      forever begin
         if (!held && taken == HOLD_AT) begin
            held = 1'b1;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_bus.ready <= (taken >= 100 && taken < 220) || ($urandom_range(99) >= 10);
            @(posedge clock);
            if (rsp_bus.valid && rsp_bus.ready) taken++;
         end
      end
   end

   initial begin
      logic [IN_W-1:0]    directed[$];
      logic [ROUND_W-1:0] phase_limit[NUM_PHASES];
      int                 phase_items[NUM_PHASES];
      reset = 1'b1;
      sent = 0;
      req_bus.valid = 1'b0;
      req_bus.radicand = '0;
      csr_bus.valid = 1'b0;
      csr_bus.iteration_limit = '0;
      directed = '{32'h0000_0000, 32'h0000_0001, 32'h0000_0002, 32'h7FFF_FFFF,
                   32'h8000_0000, 32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h0001_0000,
                   32'h0002_0000, 32'h0003_0000, 32'h0004_0000, 32'h0009_0000,
                   32'h0000_FFFF, 32'h0000_4000, 32'h0100_0000, 32'h5555_5555,
                   32'h7FFF_0000, 32'h0001_0001, 32'h4000_0000};
      phase_limit = '{6'd63, 6'd1, 6'd0, 6'd7, 6'($urandom_range(2, 62))};
      phase_items = '{260, 60, 40, 60, 80};
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) push_radicand(directed[i]);

      for (int p = 0; p < NUM_PHASES; p++) begin
         write_limit(phase_limit[p]);
         for (int i = 0; i < phase_items[p]; i++) begin
            if (p == 0 && i == 150) begin
               req_bus.valid <= 1'b0;
               wait_drained();
            end
            push_radicand(random_radicand());
         end
      end
      write_limit(LIMIT_RESET);
      push_radicand(32'h7FFF_FFFF);
      req_bus.valid <= 1'b0;

      wait_drained();
      repeat (200) @(posedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("newton_square_root_tb OK");
      end else begin
         $display("newton_square_root_tb NOT OK");
      end
      $finish;
   end

endmodule

`default_nettype wire
